// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/rpte_pkg.sv -----
package rpte_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int DEN_SH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam int DIV_NUM_W = 86;
    localparam int DIV_DEN_W = 56;
    localparam int DIV_CNT_W = 7;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_CLAMP   = 2'd2;

    localparam logic [1:0] REG_MAX_TERMS = 2'd0;
    localparam logic [1:0] REG_EPSILON   = 2'd1;
    localparam logic [1:0] REG_EXP_FLOOR = 2'd2;

    localparam logic [32:0] EXP_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic signed [23:0] x_value;
        logic [23:0]        sigma_value;
    } in_item_t;

    typedef struct packed {
        logic [31:0] density_q16;
        logic [32:0] exp_q32;
        logic [1:0]  status;
    } out_item_t;

endpackage

// ----- sv/rayleigh_pdf_taylor_exp.sv -----
// Channel  | Ports                        | Transfer
// ---------+------------------------------+-----------------------------------
// input    | start, busy, item            | at a clock edge with start high, busy low
// result   | done, result                 | at the edge ending the cycle done is high
// config   | cfg_we, cfg_index, cfg_data  | at a clock edge with cfg_we high
//
// An invalid item is answered in the cycle after its transfer, without raising busy.
// A valid item's time is set by the bit-serial divider, which yields 86 quotient bits
// for the exponent's argument, 63 per series term and 63 for the density.
// At most 126 terms run.
// Reset clears the control state and loads the register defaults.
// The receiver cannot stall; a new item may be transferred in the cycle done is high.
`include "assert_macros.svh"

module rayleigh_pdf_taylor_exp
    import rpte_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    item,
    output logic        done,
    output out_item_t   result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQX, S_SQS, S_FDL, S_FDH, S_CMP, S_RDIV,
        S_TMUL, S_TDIV, S_EXP, S_PMUL, S_PNUM, S_PDIV
    } state_t;

    state_t state_reg;

    logic [6:0]   max_terms_reg;
    logic [31:0]  eps_reg;
    logic [4:0]   floor_reg;

    logic [22:0]  x_reg;
    logic [23:0]  s_reg;
    logic [45:0]  x2_reg;
    logic [47:0]  s2_reg;
    logic [36:0]  fdl_reg;
    logic [44:0]  r_reg;
    logic [62:0]  mag_reg;
    logic signed [63:0] sum_reg;
    logic [6:0]   n_reg;
    logic [2:0]   mstep_reg;
    logic [107:0] acc_reg;
    logic [32:0]  e_reg;
    logic [1:0]   status_reg;
    logic         busy_reg;
    logic         done_reg;
    out_item_t    result_reg;

    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [63:0]  mul_p;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_CNT_W-1:0] div_bits;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quo;

    logic         in_invalid;
    logic [53:0]  fd;
    logic         clamp;
    logic [107:0] acc_sum;
    logic [107:0] p_shift;
    logic [62:0]  prod_sat;
    logic [62:0]  mag_new;
    logic signed [63:0] term;
    logic signed [64:0] sum_wide;
    logic signed [63:0] sum_new;
    logic         stop;
    logic [55:0]  pnum;
    logic [62:0]  pnum_sh;
    logic [55:0]  pden_sh;
    logic [32:0]  e_calc;
    logic         res_invalid;
    logic         res_zero;

    rpte_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    rpte_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .bits  (div_bits),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign in_invalid = item.x_value[23] || (item.sigma_value == 24'd0);
    assign fd         = {mul_p[21:0], 32'd0} + {17'd0, fdl_reg};
    assign clamp      = {8'd0, x2_reg} > fd;

    always_comb
    begin
        unique case (mstep_reg)
            3'd2, 3'd3: p_shift = {44'd0, mul_p} << 32;
            3'd4:       p_shift = {44'd0, mul_p} << 64;
            default:    p_shift = {44'd0, mul_p};
        endcase
    end

    assign acc_sum  = acc_reg + p_shift;
    assign prod_sat = (acc_sum[107:103] != 5'd0) ? {63{1'b1}} : acc_sum[102:40];

    assign mag_new  = div_quo[62:0];
    assign term     = n_reg[0] ? -$signed({1'b0, mag_new}) : $signed({1'b0, mag_new});
    assign sum_wide = {sum_reg[63], sum_reg} + {term[63], term};
    assign sum_new  = (sum_wide[64] != sum_wide[63])
                    ? (sum_wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                    : sum_wide[63:0];
    assign stop     = (mag_new < {23'd0, eps_reg, 8'd0})
                    || ({1'b0, n_reg} + 8'd1 >= {1'b0, max_terms_reg});

    always_comb
    begin
        if (sum_reg <= 64'sd0)
        begin
            e_calc = 33'd0;
        end
        else if (sum_reg >= 64'sh100_0000_0000)
        begin
            e_calc = EXP_ONE;
        end
        else
        begin
            e_calc = {1'b0, sum_reg[39:8]};
        end
    end

    assign pnum    = {1'b0, mul_p[54:0]} + (e_reg[32] ? {1'b0, x_reg, 32'd0} : 56'd0);
    assign pnum_sh = {7'd0, pnum} << NUM_SH;
    assign pden_sh = {8'd0, s2_reg} << DEN_SH;

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_SQX:
            begin
                mul_a = {9'd0, x_reg};
                mul_b = {9'd0, x_reg};
            end
            S_SQS:
            begin
                mul_a = {8'd0, s_reg};
                mul_b = {8'd0, s_reg};
            end
            S_FDL:
            begin
                mul_a = {27'd0, floor_reg};
                mul_b = {mul_p[30:0], 1'b0};
            end
            S_FDH:
            begin
                mul_a = {27'd0, floor_reg};
                mul_b = {15'd0, s2_reg[47:31]};
            end
            S_TMUL:
            begin
                unique case (mstep_reg)
                    3'd0:
                    begin
                        mul_a = mag_reg[31:0];
                        mul_b = r_reg[31:0];
                    end
                    3'd1:
                    begin
                        mul_a = mag_reg[31:0];
                        mul_b = {19'd0, r_reg[44:32]};
                    end
                    3'd2:
                    begin
                        mul_a = {1'b0, mag_reg[62:32]};
                        mul_b = r_reg[31:0];
                    end
                    3'd3:
                    begin
                        mul_a = {1'b0, mag_reg[62:32]};
                        mul_b = {19'd0, r_reg[44:32]};
                    end
                    default:
                    begin
                        mul_a = 32'd0;
                        mul_b = 32'd0;
                    end
                endcase
            end
            S_PMUL:
            begin
                mul_a = {9'd0, x_reg};
                mul_b = e_reg[31:0];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        div_bits  = '0;
        unique case (state_reg)
            S_CMP:
            begin
                div_start = !clamp;
                div_num   = {x2_reg, 40'd0};
                div_den   = {7'd0, s2_reg, 1'b0};
                div_bits  = DIV_CNT_W'(DIV_NUM_W);
            end
            S_TMUL:
            begin
                div_start = (mstep_reg == 3'd4);
                div_num   = {prod_sat, 23'd0};
                div_den   = {49'd0, n_reg};
                div_bits  = DIV_CNT_W'(63);
            end
            S_PNUM:
            begin
                div_start = 1'b1;
                div_num   = {pnum_sh, 23'd0};
                div_den   = pden_sh;
                div_bits  = DIV_CNT_W'(63);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_terms_reg <= 7'd100;
            eps_reg       <= 32'd42950;
            floor_reg     <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_TERMS: max_terms_reg <= cfg_data[6:0];
                REG_EPSILON:   eps_reg       <= cfg_data;
                REG_EXP_FLOOR: floor_reg     <= cfg_data[4:0];
                default:       max_terms_reg <= max_terms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            mstep_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        x_reg <= item.x_value[22:0];
                        s_reg <= item.sigma_value;
                        if (in_invalid)
                        begin
                            result_reg <= '{density_q16: 32'd0, exp_q32: 33'd0,
                                            status: ST_INVALID};
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            busy_reg   <= 1'b1;
                            state_reg  <= S_SQX;
                        end
                    end
                end
                S_SQX:
                begin
                    state_reg <= S_SQS;
                end
                S_SQS:
                begin
                    x2_reg    <= mul_p[45:0];
                    state_reg <= S_FDL;
                end
                S_FDL:
                begin
                    s2_reg    <= mul_p[47:0];
                    state_reg <= S_FDH;
                end
                S_FDH:
                begin
                    fdl_reg   <= mul_p[36:0];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    mag_reg   <= 63'd1 << 40;
                    sum_reg   <= 64'sh100_0000_0000;
                    n_reg     <= 7'd1;
                    mstep_reg <= 3'd0;
                    if (clamp)
                    begin
                        r_reg      <= {floor_reg, 40'd0};
                        status_reg <= ST_CLAMP;
                        state_reg  <= (max_terms_reg > 7'd1) ? S_TMUL : S_EXP;
                    end
                    else
                    begin
                        state_reg <= S_RDIV;
                    end
                end
                S_RDIV:
                begin
                    if (div_done)
                    begin
                        r_reg     <= div_quo[44:0];
                        state_reg <= (max_terms_reg > 7'd1) ? S_TMUL : S_EXP;
                    end
                end
                S_TMUL:
                begin
                    acc_reg <= (mstep_reg == 3'd0) ? 108'd0 : acc_sum;
                    if (mstep_reg == 3'd4)
                    begin
                        mstep_reg <= 3'd0;
                        state_reg <= S_TDIV;
                    end
                    else
                    begin
                        mstep_reg <= mstep_reg + 3'd1;
                    end
                end
                S_TDIV:
                begin
                    if (div_done)
                    begin
                        mag_reg <= mag_new;
                        sum_reg <= sum_new;
                        if (stop)
                        begin
                            state_reg <= S_EXP;
                        end
                        else
                        begin
                            n_reg     <= n_reg + 7'd1;
                            state_reg <= S_TMUL;
                        end
                    end
                end
                S_EXP:
                begin
                    e_reg     <= e_calc;
                    state_reg <= S_PMUL;
                end
                S_PMUL:
                begin
                    state_reg <= S_PNUM;
                end
                S_PNUM:
                begin
                    state_reg <= S_PDIV;
                end
                S_PDIV:
                begin
                    if (div_done)
                    begin
                        result_reg.density_q16 <= (div_quo[85:32] != 54'd0)
                                                ? 32'hFFFF_FFFF : div_quo[31:0];
                        result_reg.exp_q32     <= e_reg;
                        result_reg.status      <= status_reg;
                        done_reg               <= 1'b1;
                        busy_reg               <= 1'b0;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

    assign res_invalid = done && (result.status == ST_INVALID);
    assign res_zero    = (result.density_q16 == 32'd0) && (result.exp_q32 == 33'd0);

    `ASSERT_NEXT(a_valid_busy, clk, rst_n, start && !busy && !in_invalid, busy, "busy not raised")
    `ASSERT_IMPL(a_done_idle, clk, rst_n, done, !busy, "result while busy")
    `ASSERT_IMPL(a_invalid_zero, clk, rst_n, res_invalid, res_zero, "invalid result not zero")
    `ASSERT_IMPL(a_exp_range, clk, rst_n, done, result.exp_q32 <= EXP_ONE, "exponential above one")

endmodule

// ----- sv/rpte_mul.sv -----
module rpte_mul
    import rpte_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- sv/rpte_div.sv -----
`include "assert_macros.svh"

module rpte_div
    import rpte_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    input  logic [DIV_CNT_W-1:0] bits,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quo
);

    logic [DIV_NUM_W-1:0] num_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    assign rem_sh  = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign fits    = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= bits;
                num_reg <= num;
                den_reg <= den;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
                rem_reg <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
                quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

    `ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "divider done held")
    `ASSERT_NEXT(a_load_count, clk, rst_n, start, cnt_reg == $past(bits), "count not loaded")
    `ASSERT_IMPL(a_rem_below, clk, rst_n, cnt_reg != '0, rem_reg < den_reg, "remainder too big")

endmodule
